### hw/rtl/chrt_pkg.sv
// Shared types, codes and elaboration helpers for the hash ring table.
`default_nettype none
package chrt_pkg;

   localparam int DEF_TABLE_DEPTH = 64;
   localparam int DEF_KEY_BITS    = 64;
   localparam int DEF_NODE_BITS   = 16;

   // fan-in of each level of the result collection tree
   localparam int TREE_FANIN = 8;

   localparam logic [1:0] CMD_LOOKUP = 2'd0;
   localparam logic [1:0] CMD_XFER   = 2'd1;
   localparam logic [1:0] CMD_INSERT = 2'd2;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_EMPTY = 2'd1;
   localparam logic [1:0] STAT_FULL  = 2'd2;
   localparam logic [1:0] STAT_DUP   = 2'd3;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [63:0] key_id;
      logic [15:0] owner_node;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] found_owner;
      logic [63:0] successor_key;
      logic        must_transfer;
   } rsp_type;

   typedef struct packed {
      logic cmp_en;   // latch compare flags
      logic ins_en;   // shift up and take the new entry
      logic none_le;  // no stored key at or below the search key
   } cell_ctl_type;

   // number of nodes at a level of the collection tree, level 0 being the leaves
   function automatic int lvl_width(input int depth, input int level);
      int w;
      w = depth;
      for (int m = 0; m < level; m++) w = (w + TREE_FANIN - 1) / TREE_FANIN;
      return w;
   endfunction

   function automatic int tree_levels(input int depth);
      int w;
      int lv;
      w  = depth;
      lv = 0;
      while (w > 1) begin
         w  = (w + TREE_FANIN - 1) / TREE_FANIN;
         lv = lv + 1;
      end
      if (lv == 0) lv = 1;
      return lv;
   endfunction

   // first flat node index of a registered level (levels from 1)
   function automatic int tree_offset(input int depth, input int level);
      int off;
      off = 0;
      for (int m = 1; m < level; m++) off = off + lvl_width(depth, m);
      return off;
   endfunction

endpackage
`default_nettype wire

### hw/rtl/chrt_cell.sv
// One ring entry: stored key and owner, compare flags and selection of its result.
`default_nettype none
module chrt_cell #(
   parameter int KEY_BITS  = chrt_pkg::DEF_KEY_BITS,
   parameter int NODE_BITS = chrt_pkg::DEF_NODE_BITS
) (
   input  wire                         clock,
   input  wire                         reset,
   input  chrt_pkg::cell_ctl_type      ctl,
   input  wire  [KEY_BITS-1:0]         key_in,
   input  wire  [NODE_BITS-1:0]        own_in,
   input  wire                         occ,
   input  wire                         occ_next,
   input  wire                         le_next,
   input  wire  [KEY_BITS-1:0]         prev_key,
   input  wire  [NODE_BITS-1:0]        prev_own,
   input  wire                         prev_le,
   input  wire                         wrap_sel,
   output logic [KEY_BITS-1:0]         cell_key,
   output logic [NODE_BITS-1:0]        cell_own,
   output logic                        cell_le,
   output logic                        cell_eq,
   output logic [NODE_BITS+KEY_BITS-1:0] leaf
);
   import chrt_pkg::*;

   logic [KEY_BITS-1:0]  key_ff;
   logic [KEY_BITS-1:0]  key_in_sel;
   logic [NODE_BITS-1:0] own_ff;
   logic [NODE_BITS-1:0] own_in_sel;
   logic                 le_ff, le_in;
   logic                 eq_ff, eq_in;
   logic                 pred_sel, succ_sel;

   assign le_in = occ && (key_ff <= key_in);
   assign eq_in = occ && (key_ff == key_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         le_ff <= 1'b0;
         eq_ff <= 1'b0;
      end else if (ctl.cmp_en) begin
         le_ff <= le_in;
         eq_ff <= eq_in;
      end
   end

   // the first cell above the search key takes the new entry, the rest take their neighbour's
   assign key_in_sel = prev_le ? key_in : prev_key;
   assign own_in_sel = prev_le ? own_in : prev_own;

   always_ff @(posedge clock) begin
      if (ctl.ins_en && !le_ff) begin
         key_ff <= key_in_sel;
         own_ff <= own_in_sel;
      end
   end

   // predecessor is the last entry at or below the key, or the last entry when none is
   assign pred_sel = ctl.none_le ? (occ && !occ_next) : (le_ff && !le_next);
   assign succ_sel = (occ && !le_ff && prev_le) || wrap_sel;

   assign leaf     = {own_ff & {NODE_BITS{pred_sel}}, key_ff & {KEY_BITS{succ_sel}}};
   assign cell_key = key_ff;
   assign cell_own = own_ff;
   assign cell_le  = le_ff;
   assign cell_eq  = eq_ff;

endmodule
`default_nettype wire

### hw/rtl/chrt_tree.sv
// Registered OR tree that gathers the one selected value out of the cell row.
`default_nettype none
module chrt_tree #(
   parameter int LEAVES    = chrt_pkg::DEF_TABLE_DEPTH,
   parameter int DATA_BITS = chrt_pkg::DEF_NODE_BITS + chrt_pkg::DEF_KEY_BITS
) (
   input  wire                  clock,
   input  wire  [DATA_BITS-1:0] leaf [LEAVES],
   output logic [DATA_BITS-1:0] root
);
   import chrt_pkg::*;

   localparam int LEVELS = tree_levels(LEAVES);
   localparam int NODES  = tree_offset(LEAVES, LEVELS + 1);

   logic [DATA_BITS-1:0] node_ff [NODES];

   for (genvar l = 1; l <= LEVELS; l++) begin : g_lvl
      localparam int W   = lvl_width(LEAVES, l);
      localparam int PW  = lvl_width(LEAVES, l - 1);
      localparam int OFF = tree_offset(LEAVES, l);
      for (genvar j = 0; j < W; j++) begin : g_node
         logic [DATA_BITS-1:0] kid [TREE_FANIN];
         logic [DATA_BITS-1:0] node_in;
         for (genvar c = 0; c < TREE_FANIN; c++) begin : g_kid
            if (j * TREE_FANIN + c < PW) begin : g_used
               if (l == 1) begin : g_leaf
                  assign kid[c] = leaf[j * TREE_FANIN + c];
               end else begin : g_inner
                  localparam int POFF = tree_offset(LEAVES, l - 1);
                  assign kid[c] = node_ff[POFF + j * TREE_FANIN + c];
               end
            end else begin : g_pad
               assign kid[c] = '0;
            end
         end
         always_comb begin
            node_in = '0;
            for (int c = 0; c < TREE_FANIN; c++) node_in = node_in | kid[c];
         end
         always_ff @(posedge clock) begin
            node_ff[OFF + j] <= node_in;
         end
      end
   end

   assign root = node_ff[NODES-1];

endmodule
`default_nettype wire

### hw/rtl/consistent_hash_ring_table.sv
// Top level of the consistent hash ring table: cell row, collection tree and control.
`default_nettype none
// Keeps up to TABLE_DEPTH ring keys in ascending order in a row of cells, each key with
// its owner node. Insert places a new key (duplicate and full are reported), lookup and
// transfer check return the owner of the predecessor key and the successor key, with
// wraparound. One request is in flight at a time. The steps of a request are: compare the
// key in every cell; decide and shift, while the first level of the registered collection
// tree (L = ceil(log8(TABLE_DEPTH)) levels) loads; the further tree levels; load the response
// register, which waits while the previous response is stalled; then the block is free again
// before the next request is taken.
// A finished response may wait in its register while the next request is taken.
module consistent_hash_ring_table #(
   parameter int TABLE_DEPTH = chrt_pkg::DEF_TABLE_DEPTH,
   parameter int KEY_BITS    = chrt_pkg::DEF_KEY_BITS,
   parameter int NODE_BITS   = chrt_pkg::DEF_NODE_BITS
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  chrt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output chrt_pkg::rsp_type rsp_data,
   input  wire               csr_wr_en,
   input  wire  [15:0]       csr_wr_data
);
   import chrt_pkg::*;

   localparam int LEVELS    = tree_levels(TABLE_DEPTH);
   localparam int STEP_LAST = LEVELS + 1;
   localparam int SW        = $clog2(STEP_LAST + 1);
   localparam int CW        = $clog2(TABLE_DEPTH + 1);
   localparam int LDW       = NODE_BITS + KEY_BITS;

   logic [15:0]          local_node_ff;
   logic                 busy_ff;
   logic [SW-1:0]        step_ff;
   logic [CW-1:0]        count_ff;
   logic [1:0]           cmd_ff;
   logic [KEY_BITS-1:0]  key_ff;
   logic [NODE_BITS-1:0] own_ff;
   logic [1:0]           stat_ff, stat_in;
   logic                 zero_ff, zero_in;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff, rsp_in;

   logic                 req_fire, cmp_step, eval_step, out_step, out_fire;
   logic                 dup, full, empty, all_le, ins_en;
   cell_ctl_type         ctl;

   logic [TABLE_DEPTH-1:0] occ_vec, le_vec, eq_vec;
   logic [KEY_BITS-1:0]    cell_key [TABLE_DEPTH];
   logic [NODE_BITS-1:0]   cell_own [TABLE_DEPTH];
   logic [LDW-1:0]         leaf [TABLE_DEPTH];
   logic [LDW-1:0]         root;
   logic [NODE_BITS-1:0]   root_own;
   logic [KEY_BITS-1:0]    root_key;

   assign req_stall = busy_ff;
   assign req_fire  = req_valid && !busy_ff;
   assign cmp_step  = busy_ff && (step_ff == SW'(0));
   assign eval_step = busy_ff && (step_ff == SW'(1));
   assign out_step  = busy_ff && (step_ff == SW'(STEP_LAST));
   assign out_fire  = out_step && (!rsp_valid_ff || !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) local_node_ff <= '0;
      else if (csr_wr_en) local_node_ff <= csr_wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else if (req_fire) begin
         busy_ff <= 1'b1;
         step_ff <= '0;
      end else if (out_fire) begin
         busy_ff <= 1'b0;
      end else if (busy_ff && !out_step) begin
         step_ff <= step_ff + SW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff <= req_data.cmd;
         key_ff <= KEY_BITS'(req_data.key_id);
         own_ff <= NODE_BITS'(req_data.owner_node);
      end
   end

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_occ
      assign occ_vec[i] = CW'(i) < count_ff;
   end

   assign empty  = count_ff == '0;
   assign full   = count_ff == CW'(TABLE_DEPTH);
   assign dup    = |eq_vec;
   assign all_le = !empty && (le_vec == occ_vec);

   always_comb begin
      stat_in = STAT_OK;
      zero_in = 1'b1;
      ins_en  = 1'b0;
      unique case (cmd_ff) inside
         CMD_LOOKUP, CMD_XFER: begin
            if (empty) stat_in = STAT_EMPTY;
            else zero_in = 1'b0;
         end
         CMD_INSERT: begin
            if (dup) stat_in = STAT_DUP;
            else if (full) stat_in = STAT_FULL;
            else ins_en = eval_step;
         end
         default: begin
            stat_in = STAT_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) count_ff <= '0;
      else if (ins_en) count_ff <= count_ff + CW'(1);
   end

   always_ff @(posedge clock) begin
      if (eval_step) begin
         stat_ff <= stat_in;
         zero_ff <= zero_in;
      end
   end

   assign ctl.cmp_en  = cmp_step;
   assign ctl.ins_en  = ins_en;
   assign ctl.none_le = !le_vec[0];

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      logic                 occ_next, le_next, prev_le, wrap_sel;
      logic [KEY_BITS-1:0]  prev_key;
      logic [NODE_BITS-1:0] prev_own;
      if (i == 0) begin : g_head
         assign prev_key = key_ff;
         assign prev_own = own_ff;
         assign prev_le  = 1'b1;
         assign wrap_sel = all_le && occ_vec[0];
      end else begin : g_body
         assign prev_key = cell_key[i-1];
         assign prev_own = cell_own[i-1];
         assign prev_le  = le_vec[i-1];
         assign wrap_sel = 1'b0;
      end
      if (i == TABLE_DEPTH - 1) begin : g_tail
         assign occ_next = 1'b0;
         assign le_next  = 1'b0;
      end else begin : g_link
         assign occ_next = occ_vec[i+1];
         assign le_next  = le_vec[i+1];
      end
      chrt_cell #(
         .KEY_BITS (KEY_BITS),
         .NODE_BITS(NODE_BITS)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctl     (ctl),
         .key_in  (key_ff),
         .own_in  (own_ff),
         .occ     (occ_vec[i]),
         .occ_next(occ_next),
         .le_next (le_next),
         .prev_key(prev_key),
         .prev_own(prev_own),
         .prev_le (prev_le),
         .wrap_sel(wrap_sel),
         .cell_key(cell_key[i]),
         .cell_own(cell_own[i]),
         .cell_le (le_vec[i]),
         .cell_eq (eq_vec[i]),
         .leaf    (leaf[i])
      );
   end

   chrt_tree #(
      .LEAVES   (TABLE_DEPTH),
      .DATA_BITS(LDW)
   ) u_tree (
      .clock(clock),
      .leaf (leaf),
      .root (root)
   );

   assign root_own = root[LDW-1:KEY_BITS];
   assign root_key = root[KEY_BITS-1:0];

   always_comb begin
      rsp_in.status        = stat_ff;
      rsp_in.found_owner   = zero_ff ? 16'd0 : 16'(root_own);
      rsp_in.successor_key = zero_ff ? 64'd0 : 64'(root_key);
      rsp_in.must_transfer = !zero_ff && (16'(root_own) == local_node_ff);
   end

   // hold the response while stalled, drop it once taken
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (out_fire) rsp_valid_ff <= 1'b1;
      else if (!rsp_stall) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (out_fire) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   a_insert_room: assert property (@(posedge clock) disable iff (reset)
      ins_en |-> (busy_ff && !full && !dup))
      else $error("insert without room or of a present key");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (count_ff != $past(count_ff))) |->
         ($past(ins_en) && (count_ff == $past(count_ff) + CW'(1))))
      else $error("entry count changed without an insert");

   a_done_clears: assert property (@(posedge clock) disable iff (reset)
      out_fire |=> (!busy_ff && rsp_valid))
      else $error("response not presented after completion");
`endif

endmodule
`default_nettype wire
